>>> hdl/ppu_pkg.sv
// ----------------------------------------------------------------------------
// ppu_pkg
// Shared constants and types for the particle pool update unit: table size,
// command and status codes, and the control/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package ppu_pkg;

    localparam int MAX_PARTICLES = 1024;
    localparam int ADDR_W        = $clog2(MAX_PARTICLES);
    localparam int CNT_W         = ADDR_W + 1;

    // item commands
    localparam logic [1:0] CMD_ADD  = 2'd0;
    localparam logic [1:0] CMD_TICK = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_BAD_SLOT = 2'd2;

    // what the result register is loaded with
    typedef enum logic [1:0] {
        RES_OK   = 2'd0,
        RES_FULL = 2'd1,
        RES_BAD  = 2'd2,
        RES_DATA = 2'd3
    } ppu_res_t;

    // controller -> datapath
    typedef struct packed {
        logic     latch;     // capture now/step/slot, clear walk index
        logic     add_wr;    // append input particle at count
        logic     rd_idx;    // read entry at walk index
        logic     rd_last;   // read last live entry
        logic     rd_slot;   // read entry at requested slot
        logic     mul;       // register rate*step increments
        logic     wr_upd;    // write advanced entry, bump index
        logic     wr_move;   // copy last entry into index slot, count--
        logic     dec;       // count-- (last entry expired in place)
        logic     res_load;  // load result register
        ppu_res_t res_sel;
    } ppu_ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic full;       // count at capacity
        logic walk_done;  // index reached count
        logic expired;    // read entry expiry <= now
        logic is_last;    // index is the last live slot
        logic slot_ok;    // requested slot is live
        logic out_free;   // result register can take a new item
    } ppu_sts_t;

endpackage

>>> hdl/particle_pool_update_unit.sv
// ----------------------------------------------------------------------------
// particle_pool_update_unit
// Table of up to 1024 live particles with append, Euler tick and entry read.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one item: cmd selects add,
//   tick or read; the other fields are used by the matching command only.
//   Output channel (out_valid / out_stall) returns exactly one result item
//   per input item, in order: status, live_count and, for a read, the entry.
// Sequence (one item in flight; in_stall is high while an item is worked):
//   add / no-op : accepted, then loaded into the result register.
//   read        : slot check, memory read, result; no memory read when the
//                 slot is not live.
//   tick        : read, check/multiply, write back for each surviving entry;
//                 an expired last entry leaves the count; an expired entry
//                 elsewhere is replaced by the last one, examined in place.
//   The tick walk is set by the single read port of the table memories.
// The result sits in an output register; a new item is accepted while it
// waits. If the receiver stalls, the unit holds the next finished result
// until the register frees. Reset clears the live count and the control;
// table contents are not cleared and are only read below the live count.
// ----------------------------------------------------------------------------
module particle_pool_update_unit
    import ppu_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          cmd,
    input  logic signed [31:0]  pos_x,
    input  logic signed [31:0]  pos_y,
    input  logic signed [31:0]  vel_x,
    input  logic signed [31:0]  vel_y,
    input  logic signed [31:0]  angle,
    input  logic signed [31:0]  angle_rate,
    input  logic [31:0]         expiry,
    input  logic [31:0]         now,
    input  logic [15:0]         step,
    input  logic [9:0]          slot,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          status,
    output logic [10:0]         live_count,
    output logic signed [31:0]  out_x,
    output logic signed [31:0]  out_y,
    output logic signed [31:0]  out_angle,
    output logic [31:0]         out_expiry
);

    // command bundle down, status bundle up
    ppu_ctl_t ctl;
    ppu_sts_t sts;

    // sequencer: accept, walk, result handoff
    ppu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .sts      (sts),
        .ctl      (ctl)
    );

    // table memories, count, multipliers, result register
    ppu_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .sts        (sts),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .vel_x      (vel_x),
        .vel_y      (vel_y),
        .angle      (angle),
        .angle_rate (angle_rate),
        .expiry     (expiry),
        .now        (now),
        .step       (step),
        .slot       (slot),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .live_count (live_count),
        .out_x      (out_x),
        .out_y      (out_y),
        .out_angle  (out_angle),
        .out_expiry (out_expiry)
    );

endmodule

>>> hdl/ppu_ctrl.sv
// ----------------------------------------------------------------------------
// ppu_ctrl
// Sequencer for the particle pool: accepts one item at a time and steps the
// datapath through add, read and the tick walk over the live entries.
// ----------------------------------------------------------------------------
module ppu_ctrl
    import ppu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  logic [1:0] cmd,
    input  ppu_sts_t sts,
    output ppu_ctl_t ctl
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_TEST  = 7'b0000010,
        S_CHK   = 7'b0000100,
        S_UPD   = 7'b0001000,
        S_MOVE  = 7'b0010000,
        S_RDCHK = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t   state_reg, state_next;
    ppu_res_t res_reg, res_next;
    logic     rd_wait_reg, rd_wait_next;   // read data lands during S_DONE entry

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        res_next     = res_reg;
        rd_wait_next = 1'b0;
        ctl          = '0;
        ctl.res_sel  = res_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.latch = 1'b1;
                    case (cmd)
                        CMD_ADD:
                        begin
                            ctl.add_wr = !sts.full;
                            res_next   = sts.full ? RES_FULL : RES_OK;
                            state_next = S_DONE;
                        end
                        CMD_TICK: state_next = S_TEST;
                        CMD_READ: state_next = S_RDCHK;
                        default:
                        begin
                            res_next   = RES_OK;
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_TEST:
            begin
                if (sts.walk_done)
                begin
                    res_next   = RES_OK;
                    state_next = S_DONE;
                end
                else
                begin
                    ctl.rd_idx = 1'b1;
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (sts.expired)
                begin
                    if (sts.is_last)
                    begin
                        ctl.dec    = 1'b1;
                        state_next = S_TEST;
                    end
                    else
                    begin
                        ctl.rd_last = 1'b1;
                        state_next  = S_MOVE;
                    end
                end
                else
                begin
                    ctl.mul    = 1'b1;
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                ctl.wr_upd = 1'b1;
                state_next = S_TEST;
            end
            S_MOVE:
            begin
                ctl.wr_move = 1'b1;
                state_next  = S_TEST;   // moved entry is examined in place
            end
            S_RDCHK:
            begin
                if (sts.slot_ok)
                begin
                    ctl.rd_slot  = 1'b1;
                    res_next     = RES_DATA;
                    rd_wait_next = 1'b1;
                end
                else
                begin
                    res_next = RES_BAD;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_free && !rd_wait_reg)
                begin
                    ctl.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            res_reg     <= RES_OK;
            rd_wait_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            res_reg     <= res_next;
            rd_wait_reg <= rd_wait_next;
        end
    end

`ifndef SYNTH
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg != S_IDLE))
        else $error("item accepted but controller stayed idle");

    a_load_leaves: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.res_load |=> (state_reg == S_IDLE))
        else $error("result loaded but controller did not return to idle");

    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({ctl.add_wr, ctl.wr_upd, ctl.wr_move, ctl.dec}) <= 1)
        else $error("more than one table write or count change in a cycle");
`endif

endmodule

>>> hdl/ppu_dpath.sv
// ----------------------------------------------------------------------------
// ppu_dpath
// Particle table datapath: four single-port-read memories, live count, walk
// index, three rate*step multipliers and the result register.
// ----------------------------------------------------------------------------
module ppu_dpath
    import ppu_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  ppu_ctl_t            ctl,
    output ppu_sts_t            sts,
    input  logic signed [31:0]  pos_x,
    input  logic signed [31:0]  pos_y,
    input  logic signed [31:0]  vel_x,
    input  logic signed [31:0]  vel_y,
    input  logic signed [31:0]  angle,
    input  logic signed [31:0]  angle_rate,
    input  logic [31:0]         expiry,
    input  logic [31:0]         now,
    input  logic [15:0]         step,
    input  logic [9:0]          slot,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          status,
    output logic [10:0]         live_count,
    output logic signed [31:0]  out_x,
    output logic signed [31:0]  out_y,
    output logic signed [31:0]  out_angle,
    output logic [31:0]         out_expiry
);

    logic [63:0] pos_mem [MAX_PARTICLES];
    logic [63:0] vel_mem [MAX_PARTICLES];
    logic [63:0] ang_mem [MAX_PARTICLES];
    logic [31:0] exp_mem [MAX_PARTICLES];

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [31:0]       now_reg;
    logic [15:0]       step_reg;
    logic [9:0]        slot_reg;

    logic [63:0]       pos_rd_reg, vel_rd_reg, ang_rd_reg;
    logic [31:0]       exp_rd_reg;
    logic [31:0]       inc_x_reg, inc_y_reg, inc_a_reg;

    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [63:0]       pos_wd, vel_wd, ang_wd;
    logic [31:0]       exp_wd;
    logic [CNT_W-1:0]  last_idx;

    logic signed [48:0] mul_x, mul_y, mul_a;

    logic              out_valid_reg;
    logic [1:0]        status_reg;
    logic [10:0]       live_count_reg;
    logic [31:0]       out_x_reg, out_y_reg, out_angle_reg, out_expiry_reg;

    assign last_idx = count_reg - 1'b1;

    // status to controller
    assign sts.full      = (count_reg == CNT_W'(MAX_PARTICLES));
    assign sts.walk_done = (idx_reg >= count_reg);
    assign sts.expired   = (exp_rd_reg <= now_reg);
    assign sts.is_last   = (idx_reg == last_idx);
    assign sts.slot_ok   = (CNT_W'(slot_reg) < count_reg);
    assign sts.out_free  = !out_valid_reg || !out_stall;

    // read port address
    always_comb
    begin
        rd_en   = ctl.rd_idx || ctl.rd_last || ctl.rd_slot;
        rd_addr = idx_reg[ADDR_W-1:0];
        if (ctl.rd_last)
            rd_addr = last_idx[ADDR_W-1:0];
        else if (ctl.rd_slot)
            rd_addr = ADDR_W'(slot_reg);
    end

    // rate * step, floor to Q16.16 by taking bits [47:16]
    assign mul_x = $signed(vel_rd_reg[31:0])  * $signed({1'b0, step_reg});
    assign mul_y = $signed(vel_rd_reg[63:32]) * $signed({1'b0, step_reg});
    assign mul_a = $signed(ang_rd_reg[63:32]) * $signed({1'b0, step_reg});

    // write port
    always_comb
    begin
        wr_en   = ctl.add_wr || ctl.wr_upd || ctl.wr_move;
        wr_addr = idx_reg[ADDR_W-1:0];
        pos_wd  = pos_rd_reg;
        vel_wd  = vel_rd_reg;
        ang_wd  = ang_rd_reg;
        exp_wd  = exp_rd_reg;
        if (ctl.add_wr)
        begin
            wr_addr = count_reg[ADDR_W-1:0];
            pos_wd  = {pos_y, pos_x};
            vel_wd  = {vel_y, vel_x};
            ang_wd  = {angle_rate, angle};
            exp_wd  = expiry;
        end
        else if (ctl.wr_upd)
        begin
            pos_wd = {pos_rd_reg[63:32] + inc_y_reg, pos_rd_reg[31:0] + inc_x_reg};
            ang_wd = {ang_rd_reg[63:32], ang_rd_reg[31:0] + inc_a_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pos_mem[wr_addr] <= pos_wd;
            vel_mem[wr_addr] <= vel_wd;
            ang_mem[wr_addr] <= ang_wd;
            exp_mem[wr_addr] <= exp_wd;
        end
        if (rd_en)
        begin
            pos_rd_reg <= pos_mem[rd_addr];
            vel_rd_reg <= vel_mem[rd_addr];
            ang_rd_reg <= ang_mem[rd_addr];
            exp_rd_reg <= exp_mem[rd_addr];
        end
    end

    // item operands and increments
    always_ff @(posedge clk)
    begin
        if (ctl.latch)
        begin
            now_reg  <= now;
            step_reg <= step;
            slot_reg <= slot;
        end
        if (ctl.mul)
        begin
            inc_x_reg <= mul_x[47:16];
            inc_y_reg <= mul_y[47:16];
            inc_a_reg <= mul_a[47:16];
        end
    end

    // count and walk index
    always_comb
    begin
        count_next = count_reg;
        idx_next   = idx_reg;
        if (ctl.add_wr)
            count_next = count_reg + 1'b1;
        else if (ctl.wr_move || ctl.dec)
            count_next = last_idx;
        if (ctl.latch)
            idx_next = '0;
        else if (ctl.wr_upd)
            idx_next = idx_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctl.res_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.res_load)
        begin
            live_count_reg <= 11'(count_reg);
            out_x_reg      <= '0;
            out_y_reg      <= '0;
            out_angle_reg  <= '0;
            out_expiry_reg <= '0;
            case (ctl.res_sel)
                RES_OK:   status_reg <= ST_OK;
                RES_FULL: status_reg <= ST_FULL;
                RES_BAD:  status_reg <= ST_BAD_SLOT;
                RES_DATA:
                begin
                    status_reg     <= ST_OK;
                    out_x_reg      <= pos_rd_reg[31:0];
                    out_y_reg      <= pos_rd_reg[63:32];
                    out_angle_reg  <= ang_rd_reg[31:0];
                    out_expiry_reg <= exp_rd_reg;
                end
                default:  status_reg <= ST_OK;
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign live_count = live_count_reg;
    assign out_x      = out_x_reg;
    assign out_y      = out_y_reg;
    assign out_angle  = out_angle_reg;
    assign out_expiry = out_expiry_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_PARTICLES))
        else $error("live count above table size");

    a_add_room: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.add_wr |-> (count_reg < CNT_W'(MAX_PARTICLES)))
        else $error("append into a full table");

    a_move_below_last: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.wr_move |-> (idx_reg < last_idx))
        else $error("entry move with index not below last entry");

    a_upd_advance: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.wr_upd |=> (idx_reg == $past(idx_reg) + 1'b1))
        else $error("walk index did not advance after update");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.res_load |-> (!out_valid_reg || !out_stall))
        else $error("result overwritten while still pending");
`endif

endmodule
